// File: sv/swps_pkg.sv
package swps_pkg;

  // Data word width shared by all fields.
  localparam int WORD_W = 32;

  // Window size register.
  localparam int CFG_W = 5;
  localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = 5'd10;
  localparam int MIN_SIZE = 2;

  // Divider steps, one quotient bit each.
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [WORD_W-1:0] S32_TOP_VAL    = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] S32_BOTTOM_VAL = 32'h8000_0000;

  typedef struct packed {
    logic        [WORD_W-1:0] sample_time;
    logic signed [WORD_W-1:0] sample_magnitude;
    logic signed [WORD_W-1:0] original_magnitude;
  } in_word_t;

  typedef struct packed {
    logic        [WORD_W-1:0] peak_time;
    logic signed [WORD_W-1:0] peak_score;
    logic signed [WORD_W-1:0] peak_original_magnitude;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MID,
    ST_MCAP,
    ST_ADDR,
    ST_DIFF,
    ST_SUM,
    ST_TOTAL,
    ST_ABS,
    ST_DIV,
    ST_SIGN,
    ST_OUT
  } state_t;

endpackage

// File: sv/sliding_window_peak_score.sv
// A word that does not complete the window is absorbed in its acceptance cycle; one that
// completes a window of N entries starts a scoring pass whose result is then registered:
// address, difference and sum steps per neighbor, the last two on the shared adder, one
// address step for the middle entry, 32 divider steps, and middle fetch, total, absolute
// value, sign and load. The input stalls until the result is loaded, later if one still waits.
// Synchronous active-low reset clears sequencer, fill, head and output valid, sets size 10.
module sliding_window_peak_score #(
  parameter int WINDOW_MAX = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  swps_pkg::in_word_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output swps_pkg::out_word_t            out_data,
  input  logic                           cfg_write_en,
  input  logic [swps_pkg::CFG_W-1:0]     cfg_write_data
);

  import swps_pkg::*;

  // Index width for the window memories and size width that can hold WINDOW_MAX.
  localparam int IW = $clog2(WINDOW_MAX);
  localparam int SW = $clog2(WINDOW_MAX + 1);

  // The window is a circular buffer: logical entry 0 (the oldest) lives at head_r.
  // Dropping the oldest entry after a result is a head advance, not a copy.
  function automatic logic [IW-1:0] wrap_idx(input logic [IW-1:0] base,
                                              input logic [IW-1:0] ofs);
    logic [IW:0] s;
    s = {1'b0, base} + {1'b0, ofs};
    if (s >= (IW+1)'(WINDOW_MAX)) begin
      s = s - (IW+1)'(WINDOW_MAX);
    end
    return s[IW-1:0];
  endfunction

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]   cfg_r, cfg_nxt;
  logic [IW-1:0]      fill_r, fill_nxt;
  logic [IW-1:0]      head_r, head_nxt;
  logic [IW-1:0]      idx_r, idx_nxt;
  logic [WORD_W-1:0]  mmag_r, mmag_nxt;
  logic [WORD_W-1:0]  acc_r, acc_nxt;
  logic [WORD_W-1:0]  left_r, left_nxt;
  logic [WORD_W-1:0]  diff_r, diff_nxt;
  logic [WORD_W-1:0]  quo_r, quo_nxt;
  logic               neg_r, neg_nxt;
  logic [IW-1:0]      rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [WORD_W-1:0]  pk_time_r, pk_time_nxt;
  logic [WORD_W-1:0]  pk_orig_r, pk_orig_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_data_r, out_data_nxt;

  // Sample memories, one write and one registered read per cycle each.
  logic [WORD_W-1:0] time_mem [WINDOW_MAX];
  logic [WORD_W-1:0] mag_mem  [WINDOW_MAX];
  logic [WORD_W-1:0] orig_mem [WINDOW_MAX];
  logic [WORD_W-1:0] time_rd_r, mag_rd_r, orig_rd_r;

  logic          in_accept;
  logic          out_take;
  logic          completes;
  logic [SW-1:0] size;
  logic [IW-1:0] mid;
  logic [IW-1:0] last;
  logic [IW-1:0] wr_addr;
  logic [IW-1:0] rd_log;
  logic [IW-1:0] rd_addr;

  // Shared adder: the neighbor differences, saturating sums and negations run through it.
  logic [WORD_W-1:0] alu_a, alu_b;
  logic              alu_cin;
  logic [WORD_W:0]   alu_sum;
  logic [WORD_W-1:0] alu_wrap, alu_sat;

  // One restoring divider step.
  logic [IW:0] div_shift, div_diff;
  logic        div_ge;

  // The register value is clamped into the supported window range.
  always_comb begin
    if (cfg_r < CFG_W'(MIN_SIZE)) begin
      size = SW'(MIN_SIZE);
    end else if (32'(cfg_r) > WINDOW_MAX) begin
      size = SW'(WINDOW_MAX);
    end else begin
      size = SW'(cfg_r);
    end
  end

  assign mid  = IW'(size >> 1);
  assign last = IW'(size - SW'(1));

  assign in_accept = in_valid && (state_r == ST_IDLE);
  assign in_stall  = (state_r != ST_IDLE);
  assign out_take  = out_valid_r && !out_stall;
  assign completes = ((SW'(fill_r) + SW'(1)) == size);

  assign wr_addr = wrap_idx(head_r, fill_r);
  assign rd_log  = (state_r == ST_MID) ? mid : idx_r;
  assign rd_addr = wrap_idx(head_r, rd_log);

  assign alu_sum  = {alu_a[WORD_W-1], alu_a} + {alu_b[WORD_W-1], alu_b}
                  + {{WORD_W{1'b0}}, alu_cin};
  assign alu_wrap = alu_sum[WORD_W-1:0];
  // Overflow shows as the two top bits of the exact sum disagreeing.
  assign alu_sat  = (alu_sum[WORD_W] != alu_sum[WORD_W-1]) ?
                    (alu_sum[WORD_W] ? S32_BOTTOM_VAL : S32_TOP_VAL) : alu_sum[WORD_W-1:0];

  // The divisor is window_size - 1, which is also the last logical index.
  assign div_shift = {rem_r, quo_r[WORD_W-1]};
  assign div_ge    = (div_shift >= {1'b0, last});
  assign div_diff  = div_shift - {1'b0, last};

  always_ff @(posedge clk) begin
    if (in_accept) begin
      time_mem[wr_addr] <= in_data.sample_time;
      mag_mem[wr_addr]  <= in_data.sample_magnitude;
      orig_mem[wr_addr] <= in_data.original_magnitude;
    end
    time_rd_r <= time_mem[rd_addr];
    mag_rd_r  <= mag_mem[rd_addr];
    orig_rd_r <= orig_mem[rd_addr];
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept && completes) begin
          state_nxt = ST_MID;
        end
      end
      ST_MID:  state_nxt = ST_MCAP;
      ST_MCAP: state_nxt = ST_ADDR;
      ST_ADDR: begin
        if (idx_r == mid) begin
          state_nxt = (idx_r == last) ? ST_TOTAL : ST_ADDR;
        end else begin
          state_nxt = ST_DIFF;
        end
      end
      ST_DIFF: state_nxt = ST_SUM;
      ST_SUM: begin
        state_nxt = (idx_r == last) ? ST_TOTAL : ST_ADDR;
      end
      ST_TOTAL: state_nxt = ST_ABS;
      ST_ABS:   state_nxt = ST_DIV;
      ST_DIV: begin
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_SIGN;
        end
      end
      ST_SIGN: state_nxt = ST_OUT;
      ST_OUT: begin
        if (!out_valid_r || out_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath control and register updates per state.
  always_comb begin
    cfg_nxt       = cfg_r;
    fill_nxt      = fill_r;
    head_nxt      = head_r;
    idx_nxt       = idx_r;
    mmag_nxt      = mmag_r;
    acc_nxt       = acc_r;
    left_nxt      = left_r;
    diff_nxt      = diff_r;
    quo_nxt       = quo_r;
    neg_nxt       = neg_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    pk_time_nxt   = pk_time_r;
    pk_orig_nxt   = pk_orig_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_take;
    alu_a         = acc_r;
    alu_b         = diff_r;
    alu_cin       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        // A completing word leaves the count unchanged: the oldest entry goes
        // out when the result is delivered.
        if (in_accept && !completes) begin
          fill_nxt = fill_r + IW'(1);
        end
      end
      ST_MID: begin
      end
      ST_MCAP: begin
        mmag_nxt    = mag_rd_r;
        pk_time_nxt = time_rd_r;
        pk_orig_nxt = orig_rd_r;
        idx_nxt     = '0;
        acc_nxt     = '0;
        left_nxt    = '0;
      end
      ST_ADDR: begin
        // At the middle entry the left sum is parked and the right sum starts.
        if (idx_r == mid) begin
          left_nxt = acc_r;
          acc_nxt  = '0;
          if (idx_r != last) begin
            idx_nxt = idx_r + IW'(1);
          end
        end
      end
      ST_DIFF: begin
        alu_a    = mmag_r;
        alu_b    = ~mag_rd_r;
        alu_cin  = 1'b1;
        diff_nxt = alu_wrap;
      end
      ST_SUM: begin
        acc_nxt = alu_sat;
        if (idx_r != last) begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      ST_TOTAL: begin
        alu_a   = left_r;
        alu_b   = acc_r;
        acc_nxt = alu_sat;
      end
      ST_ABS: begin
        alu_a   = '0;
        alu_b   = ~acc_r;
        alu_cin = 1'b1;
        neg_nxt = acc_r[WORD_W-1];
        quo_nxt = acc_r[WORD_W-1] ? alu_wrap : acc_r;
        rem_nxt = '0;
        cnt_nxt = '0;
      end
      ST_DIV: begin
        rem_nxt = div_ge ? div_diff[IW-1:0] : div_shift[IW-1:0];
        quo_nxt = {quo_r[WORD_W-2:0], div_ge};
        cnt_nxt = cnt_r + DIV_CNT_W'(1);
      end
      ST_SIGN: begin
        alu_a   = '0;
        alu_b   = ~quo_r;
        alu_cin = 1'b1;
        acc_nxt = neg_r ? alu_wrap : quo_r;
      end
      ST_OUT: begin
        if (!out_valid_r || out_take) begin
          out_valid_nxt                        = 1'b1;
          out_data_nxt.peak_time               = pk_time_r;
          out_data_nxt.peak_score              = acc_r;
          out_data_nxt.peak_original_magnitude = pk_orig_r;
          head_nxt                             = wrap_idx(head_r, IW'(1));
        end
      end
      default: begin
      end
    endcase

    // A new window size restarts filling from empty.
    if (cfg_write_en) begin
      cfg_nxt  = cfg_write_data;
      fill_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_r       <= WINDOW_SIZE_RESET;
      fill_r      <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cfg_r       <= cfg_nxt;
      fill_r      <= fill_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    mmag_r     <= mmag_nxt;
    acc_r      <= acc_nxt;
    left_r     <= left_nxt;
    diff_r     <= diff_nxt;
    quo_r      <= quo_nxt;
    neg_r      <= neg_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    pk_time_r  <= pk_time_nxt;
    pk_orig_r  <= pk_orig_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // While idle the fill count is always short of a full window.
  a_fill_below_size: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (SW'(fill_r) < size))
    else $error("fill count reached window size while idle");

  // A new result appears only as the sequencer leaves its delivery state.
  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result raised outside delivery state");

  // The neighbor walk never runs past the last window entry.
  a_idx_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADDR || state_r == ST_DIFF || state_r == ST_SUM) |-> (idx_r <= last))
    else $error("window index beyond last entry");

endmodule

// File: bench/swps_score_checker.sv
`timescale 1ns / 1ps

// Watches the input, result and register ports, keeps a shadow copy of the
// window and scores every window that fills. Results are compared in order.
module swps_score_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  swps_pkg::in_word_t           in_data,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  swps_pkg::out_word_t          out_data,
  input  logic                         cfg_write_en,
  input  logic [swps_pkg::CFG_W-1:0]   cfg_write_data,
  output int                           score_errors,
  output int                           peaks_pending,
  output int                           words_taken,
  output int                           peaks_seen
);

  import swps_pkg::*;

  localparam int     DEPTH    = 16;
  localparam int     SHOW_MAX = 10;
  localparam longint SUM_HI   = longint'($signed(S32_TOP_VAL));
  localparam longint SUM_LO   = longint'($signed(S32_BOTTOM_VAL));

  logic        [WORD_W-1:0] win_time [DEPTH];
  logic signed [WORD_W-1:0] win_mag  [DEPTH];
  logic signed [WORD_W-1:0] win_orig [DEPTH];
  int unsigned              held;
  logic [CFG_W-1:0]         size_reg;
  out_word_t                expected_peaks [$];
  out_word_t                want;
  int unsigned              span;
  int                       errs;
  int                       n_in;
  int                       n_out;

  function automatic int unsigned active_size(logic [CFG_W-1:0] r);
    if (r < MIN_SIZE) return MIN_SIZE;
    if (r > DEPTH) return DEPTH;
    return int'(r);
  endfunction

  function automatic longint sat_sum(longint acc, longint add);
    longint s;
    s = acc + add;
    if (s > SUM_HI) return SUM_HI;
    if (s < SUM_LO) return SUM_LO;
    return s;
  endfunction

  // Scores the middle entry of a full window of n entries.
  function automatic out_word_t predict_peak(int unsigned n);
    int unsigned              mid;
    longint                   left;
    longint                   right;
    longint                   total;
    logic signed [WORD_W-1:0] diff;
    out_word_t                r;
    mid   = n / 2;
    left  = 0;
    right = 0;
    for (int i = 0; i < mid; i++) begin
      diff = win_mag[mid] - win_mag[i];
      left = sat_sum(left, longint'(diff));
    end
    for (int i = mid + 1; i < n; i++) begin
      diff  = win_mag[mid] - win_mag[i];
      right = sat_sum(right, longint'(diff));
    end
    total = sat_sum(left, right);
    r.peak_time               = win_time[mid];
    r.peak_score              = 32'(total / longint'(n - 1));
    r.peak_original_magnitude = win_orig[mid];
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      held     = 0;
      size_reg = WINDOW_SIZE_RESET;
      expected_peaks.delete();
      errs     = 0;
      n_in     = 0;
      n_out    = 0;
    end else begin
      if (out_valid && !out_stall) begin
        n_out++;
        if (expected_peaks.size() == 0) begin
          errs++;
          if (errs <= SHOW_MAX)
            $display("%0t: unexpected result word time %h score %0d orig %0d", $realtime,
                     out_data.peak_time, out_data.peak_score,
                     out_data.peak_original_magnitude);
        end else begin
          want = expected_peaks.pop_front();
          if (out_data.peak_time !== want.peak_time ||
              out_data.peak_score !== want.peak_score ||
              out_data.peak_original_magnitude !== want.peak_original_magnitude) begin
            errs++;
            if (errs <= SHOW_MAX)
              $display("%0t: mismatch exp t %h s %0d o %0d, got t %h s %0d o %0d",
                       $realtime, want.peak_time, want.peak_score,
                       want.peak_original_magnitude, out_data.peak_time,
                       out_data.peak_score, out_data.peak_original_magnitude);
          end
        end
      end
      if (cfg_write_en) begin
        size_reg = cfg_write_data;
        held     = 0;
      end
      if (in_valid && !in_stall) begin
        n_in++;
        span = active_size(size_reg);
        if (held >= span) held = 0;
        win_time[held] = in_data.sample_time;
        win_mag[held]  = in_data.sample_magnitude;
        win_orig[held] = in_data.original_magnitude;
        held++;
        if (held == span) begin
          expected_peaks.push_back(predict_peak(span));
          for (int i = 0; i < span - 1; i++) begin
            win_time[i] = win_time[i + 1];
            win_mag[i]  = win_mag[i + 1];
            win_orig[i] = win_orig[i + 1];
          end
          held = span - 1;
        end
      end
    end
    score_errors  <= errs;
    peaks_pending <= expected_peaks.size();
    words_taken   <= n_in;
    peaks_seen    <= n_out;
  end

endmodule

// File: bench/sliding_window_peak_score_tb.sv
`timescale 1ns / 1ps

// Top of the bench. It makes the clock and reset, feeds sample words, plays
// the receiver and gives the verdict. All prediction and comparison lives in
// the checker instantiated next to the block.
module sliding_window_peak_score_tb;
  import swps_pkg::*;

  // This gap lets a full window of 16 finish scoring, with margin, before
  // any register write and at the very end.
  localparam int SETTLE_CYCLES = 120;
  // The long receiver hold-off, long enough that the block fills and stalls.
  localparam int HOLD_CYCLES   = 400;
  // Cycles with no word moved on either channel before the run is declared hung.
  localparam int QUIET_LIMIT   = 5000;
  localparam int PHASES        = 12;
  localparam int PHASE_WORDS   = 58;
  localparam logic signed [WORD_W-1:0] BIG_POS = 32'sd1000000000;
  localparam logic signed [WORD_W-1:0] BIG_NEG = -32'sd1000000000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_word_t            in_data;
  logic                out_valid;
  logic                out_stall;
  out_word_t           out_data;
  logic                cfg_write_en;
  logic [CFG_W-1:0]    cfg_write_data;

  int                  score_errors;
  int                  peaks_pending;
  int                  words_taken;
  int                  peaks_seen;

  // Idle rates in percent for the two sides, and the hold-off request count.
  int unsigned         send_idle;
  int unsigned         recv_idle;
  int unsigned         hold_asked;
  int unsigned         quiet_cycles;
  int                  settings_used;

  sliding_window_peak_score u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  swps_score_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .score_errors   (score_errors),
    .peaks_pending  (peaks_pending),
    .words_taken    (words_taken),
    .peaks_seen     (peaks_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Magnitudes lean toward the extremes so that the saturating sums are hit
  // in both directions, while plain random values keep every bit toggling.
  function automatic logic signed [WORD_W-1:0] pick_magnitude();
    case ($urandom_range(0, 7))
      0: return S32_TOP_VAL;
      1: return S32_BOTTOM_VAL;
      2: return $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
      3: return $signed($urandom_range(0, 2000)) - 32'sd1000;
      4: return S32_TOP_VAL - $urandom_range(0, 1000);
      5: return S32_BOTTOM_VAL + $urandom_range(0, 1000);
      default: return $signed($urandom);
    endcase
  endfunction

  // Offers one word, starting at a falling edge. Idle cycles are decided
  // before valid rises, so valid never reacts to stall, and the payload is
  // held until the word is taken. Returns at the following falling edge.
  task automatic push_word(input in_word_t w);
    while (send_idle != 0 && $urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // The register may only change while the block is idle: wait for every
  // outstanding score, let the block settle, then write.
  task automatic set_window(input logic [CFG_W-1:0] sz);
    in_valid <= 1'b0;
    while (peaks_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= sz;
    @(negedge clk);
    cfg_write_en   <= 1'b0;
    settings_used++;
  endtask

  // Receiver. It normally stalls at the current idle rate, but when a
  // hold-off is requested it stalls for a long counted stretch on its own,
  // so that the block backs up and stalls its input.
  initial begin : receiver
    int unsigned hold_left;
    int unsigned hold_served;
    out_stall   = 1'b0;
    hold_left   = 0;
    hold_served = 0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_served != hold_asked) begin
        out_stall <= 1'b1;
        hold_served++;
        hold_left = HOLD_CYCLES - 1;
      end else begin
        out_stall <= (recv_idle != 0 && $urandom_range(0, 99) < recv_idle);
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves a word.
  initial begin : watchdog
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Watchdog: no word moved for %0d cycles", QUIET_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    in_word_t           w;
    logic [CFG_W-1:0]   sz;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_write_en   = 1'b0;
    cfg_write_data = '0;
    send_idle      = 34;
    recv_idle      = 57;
    hold_asked     = 0;
    settings_used  = 1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset window of ten: the middle entry sits far above all neighbors, so
    // both partial sums saturate high. Timestamps and carried magnitudes
    // take their extremes on the way.
    for (int i = 0; i < 10; i++) begin
      w.sample_time        = (i == 0) ? '0 : ((i == 5) ? '1 : WORD_W'(i));
      w.sample_magnitude   = (i == 5) ? BIG_POS : BIG_NEG;
      w.original_magnitude = (i == 5) ? S32_BOTTOM_VAL : S32_TOP_VAL;
      push_word(w);
    end

    // A register value of zero is raised to the minimum window of two. The
    // write also throws away the nine entries left over from above. The
    // differences between the extremes wrap around.
    set_window(5'd0);
    push_word('{32'h0000_0001, S32_BOTTOM_VAL, 32'sd0});
    push_word('{32'h8000_0000, S32_TOP_VAL, -32'sd1});
    push_word('{32'h7FFF_FFFF, 32'sd0, 32'sd1});

    // Window of three: first the total saturates low, then it saturates high.
    set_window(5'd3);
    push_word('{32'h0000_0010, BIG_POS, 32'sd7});
    push_word('{32'h0000_0020, BIG_NEG, -32'sd7});
    push_word('{32'h0000_0030, BIG_POS, S32_TOP_VAL});
    push_word('{32'h0000_0040, BIG_NEG, S32_BOTTOM_VAL});

    // Random phases. The sizes include the clamped register values at both
    // ends. The idling profile changes every four phases: sender idle
    // 34/receiver 57, then swapped, then no idling at all.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:  sz = 5'd31;
        1:  sz = 5'd2;
        2:  sz = 5'd16;
        3:  sz = 5'd5;
        4:  sz = 5'd1;
        5:  sz = 5'd17;
        6:  sz = 5'd8;
        7:  sz = 5'd15;
        8:  sz = 5'd2;
        9:  sz = 5'd0;
        10: sz = 5'd10;
        default: sz = 5'd16;
      endcase
      set_window(sz);
      case (p / 4)
        0: begin
          send_idle = 34;
          recv_idle = 57;
        end
        1: begin
          send_idle = 57;
          recv_idle = 34;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      // With a window of two and no sender gaps every word scores, so a long
      // hold-off here backs the block up quickly.
      if (p == 8) hold_asked++;
      for (int k = 0; k < PHASE_WORDS; k++) begin
        w.sample_time        = ($urandom_range(0, 15) == 0) ? '1 : $urandom;
        w.sample_magnitude   = pick_magnitude();
        w.original_magnitude = $signed($urandom);
        push_word(w);
      end
    end

    // Drain and let the block settle before the verdict.
    in_valid <= 1'b0;
    while (peaks_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Fed %0d sample words and checked %0d peak scores over %0d window settings,",
             words_taken, peaks_seen, settings_used);
    $display("including clamped sizes, saturation both ways, three idle profiles and a hold-off.");
    if (score_errors == 0 && peaks_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
sv/swps_pkg.sv
sv/sliding_window_peak_score.sv
bench/swps_score_checker.sv
bench/sliding_window_peak_score_tb.sv
